@@ src/uvsph_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared types, constants and register codes for the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvsph_pkg;

  localparam int MaxSegments = 256;
  localparam int CntW        = 9;   // segment counts and grid indices
  localparam int NumW        = 25;  // dividend width of the grid divisions
  localparam int RecW        = 32;  // reciprocal width, 2^32 / count
  localparam int IdxW        = 17;  // vertex index width
  localparam int QDepth      = 4;
  localparam int QPtrW       = 2;
  localparam int QCntW       = 3;
  localparam int InDataW     = 24;
  localparam int OutDataW    = 184;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 16;

  // Quarter-wave sine polynomial coefficients, Q14
  localparam logic [14:0] SinA    = 15'd25736;
  localparam logic [13:0] SinB    = 14'd10512;
  localparam logic [10:0] SinC    = 11'd1160;
  localparam logic [14:0] Quarter = 15'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIUS    = 3'd0,
    REG_COLUMNS   = 3'd1,
    REG_ROWS      = 3'd2,
    REG_AZ_START  = 3'd3,
    REG_AZ_SPAN   = 3'd4,
    REG_POL_START = 3'd5,
    REG_POL_SPAN  = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_CELL   = 1'b1
  } op_e;

  // Effective configuration as seen by the datapath
  typedef struct packed {
    logic [15:0]     radius;
    logic [CntW-1:0] cols;
    logic [CntW-1:0] rows;
    logic [15:0]     az_start;
    logic [15:0]     az_span;
    logic [15:0]     pol_start;
    logic [15:0]     pol_span;
    logic            top_closed;
    logic            bottom_closed;
    logic [RecW-1:0] recip_cols;
    logic [RecW-1:0] recip_rows;
  } cfg_t;

  // One work entry between front and back
  typedef struct packed {
    logic            is_tri;
    logic            last;
    logic            u_zero;
    logic [NumW-1:0] n_az;
    logic [NumW-1:0] n_pol;
    logic [NumW-1:0] n_u;
    logic [NumW-1:0] n_v;
    logic [IdxW-1:0] c_first;
    logic [IdxW-1:0] c_second;
    logic [IdxW-1:0] c_third;
  } qent_t;

  // Side data carried along the back pipeline
  typedef struct packed {
    logic            is_tri;
    logic            last;
    logic            u_zero;
    logic [IdxW-1:0] c_first;
    logic [IdxW-1:0] c_second;
    logic [IdxW-1:0] c_third;
  } meta_t;

endpackage

@@ src/uv_sphere_vertex_and_index_generator_top.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex and index generator
// Front end, work queue and pipelined back end of the sphere tessellator.
// ----------------------------------------------------------------------------
// Path: an accepted item is registered in the front end, held in the work queue
//   and then passes the back-end pipeline stages into the output register.
// Throughput: one item per cycle while no division runs and neither the queue nor
//   the output stalls; a cell giving two triangles holds the front end until both of its queue entries are pushed.
// Each write of columns or rows runs a reciprocal division, during which no
//   item is accepted; reset clears queue and pipeline valids.
module uv_sphere_vertex_and_index_generator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [uvsph_pkg::InDataW-1:0]   s_axis_tdata,  // column[8:0], row[17:9]
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
  // corner_first, corner_second, corner_third
  output logic [uvsph_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [uvsph_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uvsph_pkg::CfgDataW-1:0]  cfg_data_i
);

  uvsph_pkg::cfg_t  cfg;
  logic             busy, push, q_ready, q_valid, q_pop;
  uvsph_pkg::qent_t push_data, q_data;

  uvsph_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (busy)
  );

  uvsph_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .busy_i        (busy),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_data_o   (push_data),
    .q_ready_i     (q_ready)
  );

  uvsph_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  uvsph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

@@ src/uvsph_cfg.sv @@
// ----------------------------------------------------------------------------
// UV sphere configuration registers
// Holds the registers, clamps them and computes 2^32/count reciprocals.
// ----------------------------------------------------------------------------
module uvsph_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uvsph_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uvsph_pkg::CfgDataW-1:0] cfg_data_i,
  output uvsph_pkg::cfg_t                cfg_o,
  output logic                           busy_o
);

  logic [15:0] radius_q, az_start_q, az_span_q, pol_start_q, pol_span_q;
  logic [uvsph_pkg::CntW-1:0] cols_q, rows_q, cols_eff, rows_eff;
  logic        busy_q;
  logic [5:0]  step_q;
  logic [uvsph_pkg::CntW-1:0] rem_c_q, rem_r_q;
  logic [uvsph_pkg::CntW:0]   rem_c_n, rem_r_n;
  logic [uvsph_pkg::RecW-1:0] rec_c_q, rec_r_q;
  logic        div_bit, start;
  logic [16:0] pol_end;

  assign cfg_ready_o = 1'b1;
  assign start = cfg_valid_i && (cfg_index_i == uvsph_pkg::REG_COLUMNS ||
                                 cfg_index_i == uvsph_pkg::REG_ROWS);

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 16'd256;
      cols_q      <= 9'd32;
      rows_q      <= 9'd16;
      az_start_q  <= 16'd0;
      az_span_q   <= 16'd65535;
      pol_start_q <= 16'd0;
      pol_span_q  <= 16'd32768;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        uvsph_pkg::REG_RADIUS:    radius_q    <= cfg_data_i;
        uvsph_pkg::REG_COLUMNS:   cols_q      <= cfg_data_i[uvsph_pkg::CntW-1:0];
        uvsph_pkg::REG_ROWS:      rows_q      <= cfg_data_i[uvsph_pkg::CntW-1:0];
        uvsph_pkg::REG_AZ_START:  az_start_q  <= cfg_data_i;
        uvsph_pkg::REG_AZ_SPAN:   az_span_q   <= cfg_data_i;
        uvsph_pkg::REG_POL_START: pol_start_q <= cfg_data_i;
        uvsph_pkg::REG_POL_SPAN:  pol_span_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp segment counts
  always_comb begin
    cols_eff = cols_q;
    if (cols_q < 9'd3) cols_eff = 9'd3;
    else if (cols_q > 9'(uvsph_pkg::MaxSegments)) cols_eff = 9'(uvsph_pkg::MaxSegments);
    rows_eff = rows_q;
    if (rows_q < 9'd2) rows_eff = 9'd2;
    else if (rows_q > 9'(uvsph_pkg::MaxSegments)) rows_eff = 9'(uvsph_pkg::MaxSegments);
  end

  // Restoring division of 2^32 by both counts, one quotient bit a cycle
  assign div_bit = (step_q == 6'd0);
  assign rem_c_n = {rem_c_q, div_bit};
  assign rem_r_n = {rem_r_q, div_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= 6'd0;
      rem_c_q <= '0;
      rem_r_q <= '0;
      rec_c_q <= 32'h0800_0000;
      rec_r_q <= 32'h1000_0000;
    end else if (start) begin
      busy_q  <= 1'b1;
      step_q  <= 6'd0;
      rem_c_q <= '0;
      rem_r_q <= '0;
    end else if (busy_q) begin
      if (rem_c_n >= {1'b0, cols_eff}) begin
        rem_c_q <= 9'(rem_c_n - {1'b0, cols_eff});
        rec_c_q <= {rec_c_q[30:0], 1'b1};
      end else begin
        rem_c_q <= rem_c_n[8:0];
        rec_c_q <= {rec_c_q[30:0], 1'b0};
      end
      if (rem_r_n >= {1'b0, rows_eff}) begin
        rem_r_q <= 9'(rem_r_n - {1'b0, rows_eff});
        rec_r_q <= {rec_r_q[30:0], 1'b1};
      end else begin
        rem_r_q <= rem_r_n[8:0];
        rec_r_q <= {rec_r_q[30:0], 1'b0};
      end
      step_q <= 6'(step_q + 6'd1);
      if (step_q == 6'd32) busy_q <= 1'b0;
    end
  end

  assign pol_end = {1'b0, pol_start_q} + {1'b0, pol_span_q};

  always_comb begin
    cfg_o.radius        = (radius_q < 16'd256) ? 16'd256 : radius_q;
    cfg_o.cols          = cols_eff;
    cfg_o.rows          = rows_eff;
    cfg_o.az_start      = az_start_q;
    cfg_o.az_span       = az_span_q;
    cfg_o.pol_start     = pol_start_q;
    cfg_o.pol_span      = pol_span_q;
    cfg_o.top_closed    = (pol_start_q == 16'd0);
    cfg_o.bottom_closed = (pol_end >= 17'd32768);
    cfg_o.recip_cols    = rec_c_q;
    cfg_o.recip_rows    = rec_r_q;
  end

  assign busy_o = busy_q;

endmodule

@@ src/uvsph_front.sv @@
// ----------------------------------------------------------------------------
// UV sphere front end
// Accepts items, classifies vertex and cell requests, emits work entries.
// ----------------------------------------------------------------------------
module uvsph_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uvsph_pkg::cfg_t               cfg_i,
  input  logic                          busy_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uvsph_pkg::InDataW-1:0] s_axis_tdata,  // column, row
  input  logic                          s_axis_tuser,  // op
  output logic                          push_o,
  output uvsph_pkg::qent_t              push_data_o,
  input  logic                          q_ready_i
);

  logic                       vld_q, part_q;
  uvsph_pkg::op_e             op_q;
  logic [uvsph_pkg::CntW-1:0] col_q, row_q, col_c, row_c;
  logic                       is_vtx, top, bot, in_rng, has1, has2;
  logic                       sel_first, need_push, final_part, release_item;
  logic [uvsph_pkg::CntW:0]   stride;
  logic [uvsph_pkg::IdxW-1:0] ib, ia, ic, id;

  // Classify the held item
  always_comb begin
    is_vtx = (op_q == uvsph_pkg::OP_VERTEX);
    col_c  = (col_q > cfg_i.cols) ? cfg_i.cols : col_q;
    row_c  = (row_q > cfg_i.rows) ? cfg_i.rows : row_q;
    top    = (row_c == '0) && cfg_i.top_closed;
    bot    = !top && (row_c == cfg_i.rows) && cfg_i.bottom_closed;
    in_rng = (col_q < cfg_i.cols) && (row_q < cfg_i.rows);
    has1   = (row_q != '0) || !cfg_i.top_closed;
    has2   = (row_q != 9'(cfg_i.rows - 9'd1)) || !cfg_i.bottom_closed;
    stride = {1'b0, cfg_i.cols} + 10'd1;
    ib     = 17'(17'(row_q) * 17'(stride)) + 17'(col_q);
    ia     = 17'(ib + 17'd1);
    ic     = 17'(ib + 17'(stride));
    id     = 17'(ia + 17'(stride));
    sel_first  = has1 && !part_q;
    need_push  = is_vtx || (in_rng && (has1 || has2));
    final_part = is_vtx || !(has1 && has2) || part_q;
  end

  // Build the work entry
  always_comb begin
    push_data_o          = '0;
    push_data_o.is_tri   = !is_vtx;
    push_data_o.last     = is_vtx || !sel_first || !has2;
    push_data_o.n_az     = 25'(25'(col_c) * 25'(cfg_i.az_span));
    push_data_o.n_pol    = 25'(25'(row_c) * 25'(cfg_i.pol_span));
    push_data_o.n_v      = {row_c, 16'd0};
    push_data_o.u_zero   = bot && (col_c == '0);
    if (top) begin
      push_data_o.n_u = {col_c, 1'b1, 15'd0};
    end else if (bot) begin
      push_data_o.n_u = {10'({col_c, 1'b0} - 10'd1), 15'd0};
    end else begin
      push_data_o.n_u = {col_c, 16'd0};
    end
    if (!is_vtx) begin
      if (sel_first) begin
        push_data_o.c_first  = ia;
        push_data_o.c_second = ib;
        push_data_o.c_third  = id;
      end else begin
        push_data_o.c_first  = ib;
        push_data_o.c_second = ic;
        push_data_o.c_third  = id;
      end
    end
  end

  assign push_o        = vld_q && need_push && q_ready_i;
  assign release_item  = vld_q && (!need_push || (q_ready_i && final_part));
  assign s_axis_tready = !busy_i && (!vld_q || release_item);

  // Hold the item until all its entries are pushed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      part_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      vld_q  <= 1'b1;
      part_q <= 1'b0;
    end else if (release_item) begin
      vld_q  <= 1'b0;
    end else if (push_o) begin
      part_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= uvsph_pkg::op_e'(s_axis_tuser);
      col_q <= s_axis_tdata[8:0];
      row_q <= s_axis_tdata[17:9];
    end
  end

endmodule

@@ src/uvsph_fifo.sv @@
// ----------------------------------------------------------------------------
// UV sphere work queue
// Short queue of work entries between the front and back ends.
// ----------------------------------------------------------------------------
module uvsph_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  uvsph_pkg::qent_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output uvsph_pkg::qent_t data_o,
  input  logic             pop_i
);

  uvsph_pkg::qent_t mem_q [uvsph_pkg::QDepth];
  logic [uvsph_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [uvsph_pkg::QCntW-1:0] cnt_q;

  assign ready_o = (cnt_q != 3'(uvsph_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= 2'(wr_q + 2'd1);
      if (pop_i)  rd_q <= 2'(rd_q + 2'd1);
      if (push_i && !pop_i)      cnt_q <= 3'(cnt_q + 3'd1);
      else if (pop_i && !push_i) cnt_q <= 3'(cnt_q - 3'd1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 3'(uvsph_pkg::QDepth)))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(uvsph_pkg::QDepth))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == 3'($past(cnt_q) + 3'd1)))
    else $error("queue count failed to advance");

endmodule

@@ src/uvsph_back.sv @@
// ----------------------------------------------------------------------------
// UV sphere back end
// Pipelined grid division, quarter-wave sine lanes and vertex scaling.
// ----------------------------------------------------------------------------
module uvsph_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  uvsph_pkg::cfg_t                cfg_i,
  input  logic                           q_valid_i,
  input  uvsph_pkg::qent_t               q_data_i,
  output logic                           q_pop_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [uvsph_pkg::OutDataW-1:0] m_tdata_o,
  output logic                           m_tlast_o
);

  localparam int NStg = 10;
  localparam int Lanes = 4;

  logic                    en;
  logic [NStg-1:0]         vld_q;
  uvsph_pkg::meta_t        meta_q [NStg];

  logic [Lanes-1:0][24:0]  num_q, qe_q;
  logic [Lanes-1:0][56:0]  prod_q;
  logic [Lanes-1:0][9:0]   rem_q;
  logic [Lanes-1:0][14:0]  r2_q, r3_q, r4_q, r5_q;
  logic [Lanes-1:0]        ng2_q, ng3_q, ng4_q, ng5_q;
  logic [Lanes-1:0][14:0]  x3_q, x4_q;
  logic [Lanes-1:0][13:0]  t4_q;
  logic [Lanes-1:0][14:0]  t5_q;
  logic signed [15:0]      sv_q [Lanes];
  logic [16:0]             u_q [2:8];
  logic [16:0]             v_q [2:8];
  logic signed [31:0]      cs7_q, ss7_q;
  logic signed [32:0]      rcp7_q;
  logic signed [15:0]      cp7_q;
  logic signed [48:0]      px8_q, pz8_q;
  logic signed [16:0]      py8_q;
  logic signed [15:0]      nx8_q, ny8_q, nz8_q;
  logic [uvsph_pkg::OutDataW-1:0] out_q;

  logic [Lanes-1:0][24:0]  numsel;
  logic [Lanes-1:0][24:0]  qf;
  logic [Lanes-1:0][15:0]  ang;

  // Divisor of a lane: columns for azimuth and u, rows for polar and v
  function automatic logic [8:0] lane_div(input int k, input uvsph_pkg::cfg_t c);
    return (k == 0 || k == 2) ? c.cols : c.rows;
  endfunction

  function automatic logic [31:0] lane_rec(input int k, input uvsph_pkg::cfg_t c);
    return (k == 0 || k == 2) ? c.recip_cols : c.recip_rows;
  endfunction

  // Round half away from zero by a right shift
  function automatic logic signed [48:0] rnd(input logic signed [48:0] v, input int sh);
    logic [48:0] mag;
    logic [48:0] res;
    mag = v[48] ? 49'(-v) : 49'(v);
    res = (mag + (49'd1 << (sh - 1))) >> sh;
    return v[48] ? -$signed(res) : $signed(res);
  endfunction

  assign en      = !vld_q[NStg-1] || m_tready_i;
  assign q_pop_o = en && q_valid_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], q_valid_i};
    end
  end

  always_comb begin
    numsel[0] = q_data_i.n_az;
    numsel[1] = q_data_i.n_pol;
    numsel[2] = q_data_i.n_u;
    numsel[3] = q_data_i.n_v;
    for (int k = 0; k < Lanes; k++) begin
      qf[k] = 25'(qe_q[k] + ((rem_q[k] >= {1'b0, lane_div(k, cfg_i)}) ? 25'd1 : 25'd0));
    end
    ang[0] = 16'(cfg_i.az_start + qf[0][15:0]);
    ang[1] = 16'(ang[0] + 16'd16384);
    ang[2] = 16'(cfg_i.pol_start + qf[1][15:0]);
    ang[3] = 16'(ang[2] + 16'd16384);
  end

  // Pipeline stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0].is_tri   <= q_data_i.is_tri;
      meta_q[0].last     <= q_data_i.last;
      meta_q[0].u_zero   <= q_data_i.u_zero;
      meta_q[0].c_first  <= q_data_i.c_first;
      meta_q[0].c_second <= q_data_i.c_second;
      meta_q[0].c_third  <= q_data_i.c_third;
      for (int s = 1; s < NStg; s++) meta_q[s] <= meta_q[s-1];

      for (int k = 0; k < Lanes; k++) begin
        // Stage 0: multiply by reciprocal
        num_q[k]  <= numsel[k];
        prod_q[k] <= 57'(57'(numsel[k]) * 57'(lane_rec(k, cfg_i)));
        // Stage 1: estimate quotient and remainder
        qe_q[k]   <= prod_q[k][56:32];
        rem_q[k]  <= 10'(num_q[k] - 25'(prod_q[k][56:32] * 25'(lane_div(k, cfg_i))));
        // Stage 2: fold the angle onto the first quadrant
        ng2_q[k]  <= ang[k][15];
        r2_q[k]   <= ang[k][14] ? 15'(uvsph_pkg::Quarter - {1'b0, ang[k][13:0]}) :
                                  {1'b0, ang[k][13:0]};
        // Stage 3: x squared
        x3_q[k]   <= 15'((30'(r2_q[k]) * 30'(r2_q[k]) + 30'd8192) >> 14);
        r3_q[k]   <= r2_q[k];
        ng3_q[k]  <= ng2_q[k];
        // Stage 4: B - C x^2
        t4_q[k]   <= 14'(uvsph_pkg::SinB -
                         14'((26'(uvsph_pkg::SinC) * 26'(x3_q[k]) + 26'd8192) >> 14));
        x4_q[k]   <= x3_q[k];
        r4_q[k]   <= r3_q[k];
        ng4_q[k]  <= ng3_q[k];
        // Stage 5: A - x^2 (B - C x^2)
        t5_q[k]   <= 15'(uvsph_pkg::SinA -
                         15'((29'(t4_q[k]) * 29'(x4_q[k]) + 29'd8192) >> 14));
        r5_q[k]   <= r4_q[k];
        ng5_q[k]  <= ng4_q[k];
      end

      // Stage 6: final product, saturate and sign
      for (int k = 0; k < Lanes; k++) begin
        logic [29:0] m;
        logic [15:0] mc;
        m  = (30'(t5_q[k]) * 30'(r5_q[k]) + 30'd8192) >> 14;
        mc = (m > 30'(uvsph_pkg::Quarter)) ? 16'(uvsph_pkg::Quarter) : m[15:0];
        sv_q[k] <= ng5_q[k] ? -$signed(mc) : $signed(mc);
      end

      // Stage 2 texture coordinates
      u_q[2] <= meta_q[1].u_zero ? 17'd0 :
                ((qf[2] > 25'd65536) ? 17'd65536 : qf[2][16:0]);
      v_q[2] <= 17'(25'd65536 - qf[3]);
      for (int s = 3; s <= 8; s++) begin
        u_q[s] <= u_q[s-1];
        v_q[s] <= v_q[s-1];
      end

      // Stage 7: angle products and radius times cos polar
      cs7_q  <= 32'(sv_q[1] * sv_q[2]);
      ss7_q  <= 32'(sv_q[0] * sv_q[2]);
      rcp7_q <= 33'($signed({1'b0, cfg_i.radius}) * sv_q[3]);
      cp7_q  <= sv_q[3];

      // Stage 8: scale by radius, round normals
      px8_q <= 49'($signed({1'b0, cfg_i.radius}) * cs7_q);
      pz8_q <= 49'($signed({1'b0, cfg_i.radius}) * ss7_q);
      py8_q <= 17'(rnd(49'(rcp7_q), 14));
      nx8_q <= 16'(-rnd(49'(cs7_q), 14));
      nz8_q <= 16'(rnd(49'(ss7_q), 14));
      ny8_q <= cp7_q;

      // Stage 9: output register
      if (meta_q[8].is_tri) begin
        out_q <= {meta_q[8].c_third, meta_q[8].c_second, meta_q[8].c_first, 133'd0};
      end else begin
        out_q <= {51'd0, v_q[8], u_q[8], nz8_q, ny8_q, nx8_q,
                  17'(rnd(pz8_q, 28)), py8_q, 17'(-rnd(px8_q, 28))};
      end
    end
  end

  assign m_tvalid_o = vld_q[NStg-1];
  assign m_tdata_o  = out_q;
  assign m_tlast_o  = meta_q[NStg-1].last;

endmodule
